@@ src/tsg_pkg.sv @@
// Shared widths, register codes and control types of the tone sample generator.
`timescale 1ns / 1ps

package tsg_pkg;

   localparam int FREQ_W     = 13;
   localparam int AMP_W      = 16;
   localparam int DUR_W      = 16;
   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int Q15_W      = 15;
   localparam int FRAC_W     = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int SAMPLE_RATE_DEFAULT = 16000;
   localparam int TABLE_SIZE_DEFAULT  = 1024;

   // Milliseconds per second, split as 8 * 125 for the length divider.
   localparam longint unsigned MS_PER_S = 64'd1000;
   localparam int              MS_SHIFT = 3;
   localparam longint unsigned MS_ODD   = 64'd125;
   localparam int              MS_ODD_W = 7;
   localparam longint unsigned DUR_MAX  = 64'd65535;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned Q30_HALF    = 64'd536870912;
   localparam longint unsigned Q15_PEAK    = 64'd32767;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FREQUENCY = 2'd0,
      CSR_AMPLITUDE = 2'd1,
      CSR_DURATION  = 2'd2
   } tsg_csr_type;

   typedef struct packed {
      logic valid;
      logic silent;
      logic last;
   } tsg_ctl_type;

   // Width of the sample counter, which must hold the longest tone length.
   function automatic int cnt_width(input int sample_rate);
      longint unsigned total_max;
      total_max = (longint'(sample_rate) * DUR_MAX) / MS_PER_S;
      return $clog2(total_max + 64'd1);
   endfunction

endpackage

@@ src/tsg_length.sv @@
// Tone length unit: turns the duration in milliseconds into a sample count.
`timescale 1ns / 1ps

module tsg_length import tsg_pkg::*; #(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic [DUR_W-1:0]                     duration,
   output logic                                 busy,
   output logic [cnt_width(SAMPLE_RATE)-1:0]    total
);

   localparam int CNT_W       = cnt_width(SAMPLE_RATE);
   localparam int MUL_W       = $clog2(SAMPLE_RATE + 1) + DUR_W;
   localparam int X_W         = MUL_W - MS_SHIFT;
   localparam int RECIP_SHIFT = X_W + MS_ODD_W;
   localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) + MS_ODD - 64'd1) / MS_ODD;
   localparam int RECIP_W     = $clog2(RECIP + 64'd1);
   localparam int QUO_W       = X_W + RECIP_W;

   logic [MUL_W-1:0] rate_ms_ff;
   logic [MUL_W-1:0] rate_ms_in;
   logic [QUO_W-1:0] quotient;
   logic [CNT_W-1:0] total_in;
   logic [CNT_W-1:0] total_ff;
   logic             pend_ff;

   // First step: sample rate times milliseconds.
   assign rate_ms_in = MUL_W'(SAMPLE_RATE) * MUL_W'(duration);

   // Second step: divide by 8 with a shift, then by 125 with an exact reciprocal.
   assign quotient = QUO_W'(rate_ms_ff[MUL_W-1:MS_SHIFT]) * QUO_W'(RECIP);
   assign total_in = quotient[RECIP_SHIFT +: CNT_W];

   always_ff @(posedge clock) begin
      if (load) begin
         rate_ms_ff <= rate_ms_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         total_ff <= '0;
      end else begin
         pend_ff <= load;
         if (pend_ff) begin
            total_ff <= total_in;
         end
      end
   end

   assign busy  = load || pend_ff;
   assign total = total_ff;

endmodule

@@ src/tsg_phase.sv @@
// Tick front end: sample counter, phase residue and the first pipeline register.
`timescale 1ns / 1ps

module tsg_phase import tsg_pkg::*; #(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_restart,
   output logic                                 req_stall,
   input  logic                                 length_busy,
   input  logic [FREQ_W-1:0]                    frequency,
   input  logic [cnt_width(SAMPLE_RATE)-1:0]    total,
   input  logic                                 s2_free,
   output tsg_ctl_type                          s1_ctl,
   output logic [$clog2(SAMPLE_RATE)-1:0]       s1_residue
);

   localparam int CNT_W   = cnt_width(SAMPLE_RATE);
   localparam int PHASE_W = $clog2(SAMPLE_RATE);
   localparam int NYQUIST = SAMPLE_RATE / 2;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [PHASE_W-1:0] residue_ff;
   logic [PHASE_W-1:0] residue_in;
   logic [CNT_W-1:0]   count_cur;
   logic [CNT_W-1:0]   count_inc;
   logic [PHASE_W-1:0] residue_cur;
   logic [PHASE_W-1:0] step;
   logic [PHASE_W:0]   residue_sum;
   logic [PHASE_W-1:0] residue_wrap;
   logic               produce;
   logic               accept;
   logic               s1_free;
   tsg_ctl_type        s1_ctl_ff;
   tsg_ctl_type        s1_ctl_in;
   logic [PHASE_W-1:0] s1_residue_ff;

   assign s1_free   = !s1_ctl_ff.valid || s2_free;
   assign req_stall = !s1_free || length_busy;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      count_cur   = req_restart ? '0 : count_ff;
      residue_cur = req_restart ? '0 : residue_ff;
      produce     = count_cur < total;
      count_inc   = count_cur + CNT_W'(1);

      if ({{(PHASE_W+1-FREQ_W){1'b0}}, frequency} > (PHASE_W+1)'(NYQUIST)) begin
         step = PHASE_W'(NYQUIST);
      end else begin
         step = PHASE_W'(frequency);
      end

      residue_sum = {1'b0, residue_cur} + {1'b0, step};
      if (residue_sum >= (PHASE_W+1)'(SAMPLE_RATE)) begin
         residue_wrap = PHASE_W'(residue_sum - (PHASE_W+1)'(SAMPLE_RATE));
      end else begin
         residue_wrap = residue_sum[PHASE_W-1:0];
      end

      count_in   = produce ? count_inc : count_cur;
      residue_in = produce ? residue_wrap : residue_cur;

      s1_ctl_in.valid  = produce;
      s1_ctl_in.silent = (frequency == '0);
      s1_ctl_in.last   = (count_inc == total);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         residue_ff <= '0;
         s1_ctl_ff  <= '0;
      end else begin
         if (accept) begin
            count_ff   <= count_in;
            residue_ff <= residue_in;
            s1_ctl_ff  <= s1_ctl_in;
         end else if (s2_free) begin
            s1_ctl_ff.valid <= 1'b0;
         end
      end
   end

   // The sample uses the phase before this tick's advance.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_residue_ff <= residue_cur;
      end
   end

   assign s1_ctl     = s1_ctl_ff;
   assign s1_residue = s1_residue_ff;

endmodule

@@ src/tsg_sine.sv @@
// Sine pipeline: table index, quarter-wave table, amplitude scaling and result register.
`timescale 1ns / 1ps

module tsg_sine import tsg_pkg::*; #(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEFAULT,
   parameter int TABLE_SIZE  = TABLE_SIZE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tsg_ctl_type                          s1_ctl,
   input  logic [$clog2(SAMPLE_RATE)-1:0]       s1_residue,
   output logic                                 s2_free,
   input  logic signed [AMP_W-1:0]              amplitude,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_W-1:0]           rsp_sample,
   output logic                                 rsp_last
);

   localparam int PHASE_W   = $clog2(SAMPLE_RATE);
   localparam int IDX_W     = $clog2(TABLE_SIZE);
   localparam int QUARTER   = TABLE_SIZE / 4;
   localparam int J_W       = $clog2(QUARTER + 1);
   // Exact index scaling: floor(residue * TABLE_SIZE / SAMPLE_RATE) as a
   // multiply by a rounded-up reciprocal and a shift.
   localparam int IDX_SHIFT = 2 * PHASE_W;
   localparam longint unsigned IDX_MUL =
      ((longint'(TABLE_SIZE) << IDX_SHIFT) + longint'(SAMPLE_RATE) - 64'd1) /
      longint'(SAMPLE_RATE);
   localparam int MULC_W    = $clog2(IDX_MUL + 64'd1);
   localparam int PRD_W     = (PHASE_W + MULC_W > IDX_SHIFT + IDX_W) ?
                              PHASE_W + MULC_W : IDX_SHIFT + IDX_W;

   // Q15 sine of r/TABLE_SIZE quarter turns, integer Taylor series through x^15.
   function automatic logic [Q15_W-1:0] quarter_sine(input longint unsigned r);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint unsigned v;
      x    = (r * HALF_PI_Q30) / TABLE_SIZE;
      x2   = (x * x) >> 30;
      sum  = longint'(x);
      term = ((x * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      v = (longint'(sum) * Q15_PEAK + Q30_HALF) >> 30;
      if (v > Q15_PEAK) begin
         v = Q15_PEAK;
      end
      return Q15_W'(v);
   endfunction

   logic [Q15_W-1:0] qtab [QUARTER+1];

   for (genvar g = 0; g <= QUARTER; g++) begin : g_qtab
      assign qtab[g] = quarter_sine(longint'(4 * g));
   end

   tsg_ctl_type                s2_ctl_ff;
   tsg_ctl_type                s3_ctl_ff;
   tsg_ctl_type                s4_ctl_ff;
   logic [J_W-1:0]             s2_j_ff;
   logic [J_W-1:0]             s2_j_in;
   logic                       s2_neg_ff;
   logic                       s2_neg_in;
   logic signed [SAMPLE_W-1:0] s3_tab_ff;
   logic signed [SAMPLE_W-1:0] s3_tab_in;
   logic signed [PROD_W-1:0]   s4_prod_ff;
   logic signed [PROD_W-1:0]   s4_prod_in;
   logic                       rsp_valid_ff;
   logic                       rsp_last_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_in;
   logic [PRD_W-1:0]           idx_prod;
   logic [IDX_W-1:0]           idx;
   logic signed [SAMPLE_W-1:0] tab_pos;
   logic signed [PROD_W-1:0]   rounded;
   logic                       out_free;
   logic                       s4_free;
   logic                       s3_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s4_free  = !s4_ctl_ff.valid || out_free;
   assign s3_free  = !s3_ctl_ff.valid || s4_free;
   assign s2_free  = !s2_ctl_ff.valid || s3_free;

   // Table index and quarter-wave fold.
   always_comb begin
      idx_prod = PRD_W'(s1_residue) * PRD_W'(IDX_MUL);
      idx      = idx_prod[IDX_SHIFT +: IDX_W];
      if (idx < IDX_W'(QUARTER)) begin
         s2_j_in   = J_W'(idx);
         s2_neg_in = 1'b0;
      end else if (idx < IDX_W'(2 * QUARTER)) begin
         s2_j_in   = J_W'(IDX_W'(2 * QUARTER) - idx);
         s2_neg_in = 1'b0;
      end else if (idx < IDX_W'(3 * QUARTER)) begin
         s2_j_in   = J_W'(idx - IDX_W'(2 * QUARTER));
         s2_neg_in = 1'b1;
      end else begin
         s2_j_in   = J_W'((IDX_W+1)'(TABLE_SIZE) - {1'b0, idx});
         s2_neg_in = 1'b1;
      end
   end

   // Signed table value; silence forces zero.
   always_comb begin
      tab_pos = SAMPLE_W'({1'b0, qtab[s2_j_ff]});
      if (s2_ctl_ff.silent) begin
         s3_tab_in = '0;
      end else if (s2_neg_ff) begin
         s3_tab_in = -tab_pos;
      end else begin
         s3_tab_in = tab_pos;
      end
   end

   assign s4_prod_in = PROD_W'(amplitude) * PROD_W'(s3_tab_ff);

   // Arithmetic shift with a bias on negative products truncates toward zero.
   always_comb begin
      if (s4_prod_ff < 0) begin
         rounded = s4_prod_ff + PROD_W'((1 << FRAC_W) - 1);
      end else begin
         rounded = s4_prod_ff;
      end
      rsp_sample_in = rounded[FRAC_W +: SAMPLE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff    <= '0;
         s3_ctl_ff    <= '0;
         s4_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s2_free) begin
            s2_ctl_ff <= s1_ctl;
         end
         if (s3_free) begin
            s3_ctl_ff <= s2_ctl_ff;
         end
         if (s4_free) begin
            s4_ctl_ff <= s3_ctl_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s4_ctl_ff.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_j_ff   <= s2_j_in;
         s2_neg_ff <= s2_neg_in;
      end
      if (s3_free) begin
         s3_tab_ff <= s3_tab_in;
      end
      if (s4_free) begin
         s4_prod_ff <= s4_prod_in;
      end
      if (out_free) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_last_ff   <= s4_ctl_ff.last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ src/tone_sample_generator_core.sv @@
// Top level of the tone sample generator: configuration registers and unit wiring.
`timescale 1ns / 1ps

// Usage. Three registers are written through the csr_ port: index 0 sets the
// tone frequency in hertz (zero is silence, values above half the sample rate
// are clamped), index 1 the signed peak amplitude and index 2 the duration in
// milliseconds. Each item on the req_ channel is one sample tick; req_restart
// starts the tone again at sample zero before that tick's sample is made.
// While the tone runs, a tick gives one item on the rsp_ channel with the
// 16-bit sample, and rsp_last marks the final sample. A tick after the end of
// the tone gives no item. One item is accepted per cycle while req_stall is
// low. The four stages behind the phase register, which an accepted item
// passes in order, are index scaling, quarter-wave table lookup, amplitude
// multiply and rounding into the output register.
// Each stage holds while the next one is full and stalled, so bubbles close
// up and, but for a duration write, req_stall rises only once the whole
// pipeline is full behind a stalled rsp_ channel. A write of the duration
// register stalls the req_ channel while the sample count of the tone is
// derived. Reset clears the registers, the sample count and the phase; the
// sine table is constant logic and needs no fill.
module tone_sample_generator_core import tsg_pkg::*; #(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEFAULT,
   parameter int TABLE_SIZE  = TABLE_SIZE_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_restart,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_last,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   localparam int CNT_W   = cnt_width(SAMPLE_RATE);
   localparam int PHASE_W = $clog2(SAMPLE_RATE);

   logic [FREQ_W-1:0]       frequency_ff;
   logic signed [AMP_W-1:0] amplitude_ff;
   logic                    duration_load;
   logic                    length_busy;
   logic [CNT_W-1:0]        total;
   logic                    s2_free;
   tsg_ctl_type             s1_ctl;
   logic [PHASE_W-1:0]      s1_residue;

   // Register decoder. The duration register lives in the length unit as its
   // derived sample count.
   always_ff @(posedge clock) begin
      if (reset) begin
         frequency_ff <= '0;
         amplitude_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (tsg_csr_type'(csr_index))
            CSR_FREQUENCY: frequency_ff <= csr_write_data[FREQ_W-1:0];
            CSR_AMPLITUDE: amplitude_ff <= csr_write_data[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   assign duration_load = csr_write_enable && (tsg_csr_type'(csr_index) == CSR_DURATION);

   tsg_length #(
      .SAMPLE_RATE (SAMPLE_RATE)
   ) u_length (
      .clock    (clock),
      .reset    (reset),
      .load     (duration_load),
      .duration (csr_write_data[DUR_W-1:0]),
      .busy     (length_busy),
      .total    (total)
   );

   tsg_phase #(
      .SAMPLE_RATE (SAMPLE_RATE)
   ) u_phase (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .length_busy (length_busy),
      .frequency   (frequency_ff),
      .total       (total),
      .s2_free     (s2_free),
      .s1_ctl      (s1_ctl),
      .s1_residue  (s1_residue)
   );

   tsg_sine #(
      .SAMPLE_RATE (SAMPLE_RATE),
      .TABLE_SIZE  (TABLE_SIZE)
   ) u_sine (
      .clock      (clock),
      .reset      (reset),
      .s1_ctl     (s1_ctl),
      .s1_residue (s1_residue),
      .s2_free    (s2_free),
      .amplitude  (amplitude_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (rsp_sample),
      .rsp_last   (rsp_last)
   );

endmodule

@@ sim/tone_sample_generator_core_test.sv @@
// Self-checking testbench of the tone sample generator core.
`timescale 1ns / 1ps

// The bench drives sample ticks on the req_ channel and collects samples from
// the rsp_ channel. Each accepted tick is run through a local copy of the
// generator: sample count, phase residue and a Q15 sine table that is rebuilt
// here with the same integer Taylor series. The expected item, if the tick
// makes one, goes into a queue. Each sample that leaves the core is compared
// with the oldest queued item.
//
// The run has two parts. A short directed plan covers these cases:
//    - the state right after reset,
//    - silence,
//    - a quarter-rate tone at both amplitude extremes,
//    - a tone run to its end, and ticks after the end,
//    - a frequency above Nyquist,
//    - zero and maximum duration.
// Random settings follow. Most of them are short tones that run to their last
// sample; the rest are long or empty tones, restarts and leftover ticks.
module tone_sample_generator_core_test;
   import tsg_pkg::*;

   localparam int RATE        = 16000;
   localparam int WAVE_POINTS = 1024;
   localparam int SETTLE      = 8;     // settling wait, longer than the pipeline depth
   localparam int TARGET      = 600;   // ticks to send before the stimulus stops
   localparam int IDLE_PCT    = 24;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint          ONE_Q30     = 64'sd1073741824;
   localparam longint          HALF_Q30    = 64'sd536870912;
   localparam longint          PEAK_Q15    = 64'sd32767;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } tone_out_type;

   typedef enum {ROW_WRITE, ROW_TICK} plan_kind_type;

   typedef struct {
      plan_kind_type             kind;
      tsg_csr_type               index;
      logic [CSR_DATA_W-1:0]     value;
      bit                        restart;
      int                        reps;
      bit                        known;   // expected result typed into the row
      bit                        gives;
      logic signed [SAMPLE_W-1:0] sample;
      bit                        last;
   } plan_row_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_restart = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       rsp_last;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_write_data = '0;

   // The directed rows carry a typed result along with the item. These hint
   // signals move with req_valid, so the monitor sees them for the item that
   // is being accepted.
   logic                       hint_known = 1'b0;
   logic                       hint_gives = 1'b0;
   logic signed [SAMPLE_W-1:0] hint_sample = '0;
   logic                       hint_last = 1'b0;

   // This is the local copy of the generator state and registers.
   int          sine_q15 [WAVE_POINTS];
   int unsigned reg_freq = 0;
   int          reg_amp = 0;
   int unsigned reg_dur = 0;
   int unsigned tone_count = 0;
   int unsigned tone_phase = 0;

   tone_out_type expected_samples [$];
   plan_row_type plan_rows [$];

   int  errors = 0;
   int  ticks_sent = 0;
   int  samples_made = 0;
   int  samples_checked = 0;
   int  tone_ends = 0;
   int  settings_run = 0;
   bit  no_gaps = 1'b0;
   bit  csr_open = 1'b0;

   tone_sample_generator_core #(
      .SAMPLE_RATE(RATE),
      .TABLE_SIZE(WAVE_POINTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample(rsp_sample),
      .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tone_sample_generator_core_test NOT OK");
      $finish;
   end

   // This gives sin(r/t * pi/2) in Q15 for r in 0..t. The Q30 Taylor series
   // runs through x^15, and the result is rounded and clamped to the peak.
   function automatic int quarter_wave(input longint unsigned r, input longint unsigned t);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned n;
      longint          sum;
      longint          v;
      x    = (r * HALF_PI_Q30) / t;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
         if (n[0]) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (sum * PEAK_Q15 + HALF_Q30) / ONE_Q30;
      if (v > PEAK_Q15) begin
         v = PEAK_Q15;
      end
      return int'(v);
   endfunction

   // One full period is folded onto the quarter wave. The second and fourth
   // quarters mirror the first one, and the lower half changes sign.
   initial begin : fill_sine
      longint unsigned k;
      longint unsigned u;
      longint unsigned q;
      longint unsigned r;
      int              s;
      for (k = 0; k < WAVE_POINTS; k++) begin
         u = 4 * k;
         q = u / WAVE_POINTS;
         r = u - q * WAVE_POINTS;
         s = q[0] ? quarter_wave(WAVE_POINTS - r, WAVE_POINTS) : quarter_wave(r, WAVE_POINTS);
         sine_q15[k] = q[1] ? -s : s;
      end
   end

   // This advances the local generator by one tick. A restart clears the count
   // and the phase first. Once the count has reached the tone length, the tick
   // makes nothing and the state holds.
   task automatic predict_tone_tick(input bit restart, output bit gives,
                                    output tone_out_type res);
      int unsigned tone_len;
      int unsigned step;
      int unsigned idx;
      int          prod;
      int          mag;
      int          value;
      tone_len = (RATE * reg_dur) / 1000;
      gives    = 1'b0;
      res      = '0;
      if (restart) begin
         tone_count = 0;
         tone_phase = 0;
      end
      if (tone_count < tone_len) begin
         step  = (reg_freq > RATE / 2) ? RATE / 2 : reg_freq;
         value = 0;
         if (step != 0) begin
            idx   = (tone_phase * WAVE_POINTS) / RATE;
            prod  = reg_amp * sine_q15[idx % WAVE_POINTS];
            mag   = (prod < 0) ? -prod : prod;
            value = (prod < 0) ? -(mag >> FRAC_W) : (mag >> FRAC_W);
         end
         tone_phase = tone_phase + step;
         if (tone_phase >= RATE) begin
            tone_phase = tone_phase - RATE;
         end
         tone_count = tone_count + 1;
         res.sample = value[SAMPLE_W-1:0];
         res.last   = (tone_count == tone_len);
         gives      = 1'b1;
      end
   endtask

   task automatic note_error(input string msg);
      errors++;
      if (errors <= 10) begin
         $display("%s", msg);
      end
   endtask

   // The monitor samples the handshakes as they stood before the edge. All
   // inputs change only through nonblocking assignments, so the order of
   // events within the edge does not matter.
   always @(posedge clock) begin : monitor
      bit           gives;
      tone_out_type outcome;
      tone_out_type want;
      tone_out_type got;
      if (!reset) begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FREQUENCY: reg_freq = 32'(csr_write_data[FREQ_W-1:0]);
               CSR_AMPLITUDE: reg_amp  = 32'($signed(csr_write_data[AMP_W-1:0]));
               CSR_DURATION:  reg_dur  = 32'(csr_write_data[DUR_W-1:0]);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            ticks_sent++;
            predict_tone_tick(req_restart, gives, outcome);
            if (gives) begin
               samples_made++;
            end
            if (hint_known) begin
               if (hint_gives) begin
                  want.sample = hint_sample;
                  want.last   = hint_last;
                  expected_samples.push_back(want);
               end
            end else if (gives) begin
               expected_samples.push_back(outcome);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got.sample = rsp_sample;
            got.last   = rsp_last;
            if (expected_samples.size() == 0) begin
               note_error($sformatf("unexpected sample %0d last %0b at %0t",
                                    got.sample, got.last, $realtime));
            end else begin
               want = expected_samples.pop_front();
               samples_checked++;
               if (want.last) begin
                  tone_ends++;
               end
               if (got.sample !== want.sample || got.last !== want.last) begin
                  note_error($sformatf("sample mismatch at %0t: expected %0d last %0b, got %0d last %0b",
                                       $realtime, want.sample, want.last, got.sample, got.last));
               end
            end
         end
      end
   end

   // The receiver stalls at random, except during the stretch without gaps.
   always @(posedge clock) begin
      rsp_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
   end

   function automatic void plan_write(input tsg_csr_type index, input logic [CSR_DATA_W-1:0] value);
      plan_row_type row;
      row = '{kind: ROW_WRITE, index: index, value: value, restart: 1'b0, reps: 0,
              known: 1'b0, gives: 1'b0, sample: '0, last: 1'b0};
      plan_rows.push_back(row);
   endfunction

   function automatic void plan_tick(input bit restart, input int reps, input bit known,
                                     input bit gives, input logic signed [SAMPLE_W-1:0] sample,
                                     input bit last);
      plan_row_type row;
      row = '{kind: ROW_TICK, index: CSR_FREQUENCY, value: '0, restart: restart, reps: reps,
              known: known, gives: gives, sample: sample, last: last};
      plan_rows.push_back(row);
   endfunction

   // This offers one tick. Before it the channel may sit idle at random, with a
   // new draw each idle cycle. It then holds the item until the core accepts it.
   task automatic send_tick(input bit restart, input bit known, input bit gives,
                            input logic signed [SAMPLE_W-1:0] sample, input bit last);
      while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      hint_known  <= known;
      hint_gives  <= gives;
      hint_sample <= sample;
      hint_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // This lowers valid and waits until every expected sample has left the core.
   // It then waits out SETTLE as well, because ticks that make nothing may
   // still be in the pipeline.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Back-to-back writes keep the enable high, and the caller lowers it after
   // the last write.
   task automatic write_reg(input tsg_csr_type index, input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned dur;
      int unsigned freq;
      int unsigned tone_len;
      int          span;
      int          i;
      int          drain;
      logic [CSR_DATA_W-1:0] amp;

      // The directed plan. Durations of one millisecond keep the tone at
      // sixteen samples, so the end of the tone is reached within the plan.
      plan_tick(1'b0, 1, 1'b1, 1'b0, 16'sd0, 1'b0);        // duration is zero after reset
      plan_write(CSR_FREQUENCY, 16'd0);
      plan_write(CSR_AMPLITUDE, 16'h7FFF);
      plan_write(CSR_DURATION, 16'd1);
      plan_tick(1'b0, 1, 1'b1, 1'b1, 16'sd0, 1'b0);        // silence, no restart needed
      plan_write(CSR_FREQUENCY, 16'd4000);
      plan_tick(1'b1, 1, 1'b1, 1'b1, 16'sd0, 1'b0);        // phase zero gives zero
      plan_tick(1'b0, 2, 1'b0, 1'b0, 16'sd0, 1'b0);
      plan_write(CSR_AMPLITUDE, 16'h8000);
      plan_tick(1'b1, 1, 1'b1, 1'b1, 16'sd0, 1'b0);
      plan_tick(1'b0, 15, 1'b0, 1'b0, 16'sd0, 1'b0);       // runs to the last sample
      plan_tick(1'b0, 1, 1'b1, 1'b0, 16'sd0, 1'b0);        // the tone has ended
      plan_write(CSR_FREQUENCY, 16'd8191);                 // clamped to Nyquist
      plan_write(CSR_AMPLITUDE, 16'h4000);
      plan_tick(1'b1, 1, 1'b0, 1'b0, 16'sd0, 1'b0);
      plan_write(CSR_DURATION, 16'd0);
      plan_tick(1'b1, 1, 1'b1, 1'b0, 16'sd0, 1'b0);        // zero duration makes nothing
      plan_write(CSR_DURATION, 16'hFFFF);
      plan_write(CSR_FREQUENCY, 16'd8000);
      plan_write(CSR_AMPLITUDE, 16'h7FFF);
      plan_tick(1'b1, 1, 1'b0, 1'b0, 16'sd0, 1'b0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      settings_run = 1;
      foreach (plan_rows[r]) begin
         if (plan_rows[r].kind == ROW_WRITE) begin
            if (!csr_open) begin
               wait_idle();
               csr_open = 1'b1;
            end
            write_reg(plan_rows[r].index, plan_rows[r].value);
         end else begin
            if (csr_open) begin
               csr_write_enable <= 1'b0;
               csr_open = 1'b0;
               settings_run++;
            end
            repeat (plan_rows[r].reps) begin
               send_tick(plan_rows[r].restart, plan_rows[r].known, plan_rows[r].gives,
                         plan_rows[r].sample, plan_rows[r].last);
            end
         end
      end

      // The random settings. Most tones are short enough to reach their end.
      // Long and empty tones, restarts and extra ticks fill in the rest.
      while (ticks_sent < TARGET) begin
         settings_run++;
         no_gaps = (settings_run >= 10 && settings_run <= 13);
         wait_idle();

         case ($urandom_range(5))
            0:       freq = 0;
            1:       freq = $urandom_range(8191, RATE / 2 + 1);
            2:       freq = RATE / 2;
            3:       freq = $urandom_range(50, 1);
            default: freq = $urandom_range(8191, 0);
         endcase
         case ($urandom_range(5))
            0:       amp = 16'h7FFF;
            1:       amp = 16'h8000;
            default: amp = CSR_DATA_W'($urandom());
         endcase
         i = $urandom_range(99);
         if (i < 10) begin
            dur = 0;
         end else if (i < 70) begin
            dur = $urandom_range(4, 1);
         end else if (i < 80) begin
            dur = 32'hFFFF;
         end else begin
            dur = $urandom_range(16'hFFFF, 0);
         end

         write_reg(CSR_FREQUENCY, freq[CSR_DATA_W-1:0]);
         write_reg(CSR_AMPLITUDE, amp);
         write_reg(CSR_DURATION, dur[CSR_DATA_W-1:0]);
         csr_write_enable <= 1'b0;

         tone_len = (RATE * dur) / 1000;
         if (tone_len > 0 && tone_len <= 64) begin
            span = tone_len + $urandom_range(3, 0);
         end else begin
            span = $urandom_range(40, 2);
         end
         for (i = 0; i < span; i++) begin
            send_tick((i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0),
                      1'b0, 1'b0, 16'sd0, 1'b0);
         end
      end

      req_valid <= 1'b0;
      no_gaps = 1'b0;
      drain = 0;
      while (expected_samples.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE) @(posedge clock);
      if (expected_samples.size() != 0) begin
         note_error($sformatf("%0d expected samples never arrived", expected_samples.size()));
      end

      $display("Ran %0d ticks over %0d register settings, including silence, Nyquist clamp and",
               ticks_sent, settings_run);
      $display("zero or maximum duration; %0d samples checked, %0d tone ends seen, %0d errors.",
               samples_checked, tone_ends, errors);
      if (errors == 0) begin
         $display("tone_sample_generator_core_test OK");
      end else begin
         $display("tone_sample_generator_core_test NOT OK");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/tsg_pkg.sv
src/tsg_length.sv
src/tsg_phase.sv
src/tsg_sine.sv
src/tone_sample_generator_core.sv
sim/tone_sample_generator_core_test.sv
